// File: design/e313q_pkg.sv
// Shared constants and elaboration-time table functions for the 3-1-3 Euler to quaternion block.
package e313q_pkg;

  // Pi in radians with 60 fraction bits.
  localparam logic [63:0] PI_Z = 64'h3243F6A8885A308D;

  // Split points of the half-angle product into partial products.
  localparam int MAG_SPLIT = 24;
  localparam int PI_SPLIT  = 31;
  localparam logic [PI_SPLIT-1:0] PI_LO = PI_Z[PI_SPLIT-1:0];
  localparam logic [PI_SPLIT-1:0] PI_HI = PI_Z[2*PI_SPLIT-1:PI_SPLIT];

  // Floor of 2^e / d by long division; only evaluated for constants.
  function automatic logic [63:0] div_pow2(input int e, input int d);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 62; b >= 0; b--) begin
      rem = {rem[62:0], (b == e)};
      if (rem >= 64'(d)) begin
        rem = rem - 64'(d);
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Arctangent of 2^-i in radians with 60 fraction bits, from the alternating series.
  function automatic logic signed [63:0] atan_entry(input int i);
    logic signed [63:0] acc;
    int e;
    acc = '0;
    if (i == 0) begin
      return signed'((PI_Z + 64'd2) >> 2);
    end
    for (int k = 0; k < 64; k++) begin
      e = 62 - i * (2 * k + 1);
      if (e >= 0) begin
        if ((k & 1) != 0) begin
          acc = acc - signed'(div_pow2(e, 2 * k + 1));
        end else begin
          acc = acc + signed'(div_pow2(e, 2 * k + 1));
        end
      end
    end
    return (acc + 64'sd2) >>> 2;
  endfunction

endpackage

// File: design/e313q_cordic.sv
// One angle lane: half-angle scaling followed by a pipelined rotation-mode CORDIC.
module e313q_cordic #(
  parameter int AW = 32,
  parameter int FB = 30,
  parameter int CS = 30
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] angle,
  input  logic                 unused_tie,
  output logic signed [FB+1:0] cos_o,
  output logic signed [FB+1:0] sin_o
);

  localparam int CW   = FB + 2;
  localparam int MW   = 2 * e313q_pkg::MAG_SPLIT;
  localparam int PW   = e313q_pkg::MAG_SPLIT + e313q_pkg::PI_SPLIT;
  localparam int SUMW = MW + 2 * e313q_pkg::PI_SPLIT;
  localparam logic signed [CW-1:0] ONE_C = CW'(1) << FB;

  // Half angle: magnitude of the angle times pi, as four partial products.
  logic [AW-1:0] mag_w;
  logic [MW-1:0] mag_ext;
  logic [PW-1:0] p_ll_nxt, p_lh_nxt, p_hl_nxt, p_hh_nxt;
  logic [PW-1:0] p_ll_r, p_lh_r, p_hl_r, p_hh_r;
  logic          neg_nxt, neg_r;

  assign mag_w   = angle[AW-1] ? AW'(~angle + AW'(1)) : AW'(angle);
  assign mag_ext = MW'(mag_w);
  assign neg_nxt = angle[AW-1] & ~unused_tie;

  assign p_ll_nxt = PW'(mag_ext[e313q_pkg::MAG_SPLIT-1:0]) * PW'(e313q_pkg::PI_LO);
  assign p_lh_nxt = PW'(mag_ext[e313q_pkg::MAG_SPLIT-1:0]) * PW'(e313q_pkg::PI_HI);
  assign p_hl_nxt = PW'(mag_ext[MW-1:e313q_pkg::MAG_SPLIT]) * PW'(e313q_pkg::PI_LO);
  assign p_hh_nxt = PW'(mag_ext[MW-1:e313q_pkg::MAG_SPLIT]) * PW'(e313q_pkg::PI_HI);

  // Sum the partial products, round and rescale to 60 fraction bits.
  logic [SUMW-1:0]    sum_w;
  logic [62:0]        zmag_w;
  logic signed [63:0] z0_nxt, z0_r;

  assign sum_w = SUMW'(p_ll_r)
               + (SUMW'(p_hl_r) << e313q_pkg::MAG_SPLIT)
               + (SUMW'(p_lh_r) << e313q_pkg::PI_SPLIT)
               + (SUMW'(p_hh_r) << (e313q_pkg::MAG_SPLIT + e313q_pkg::PI_SPLIT))
               + (SUMW'(1) << (AW - 1));
  assign zmag_w = 63'(sum_w >> AW);
  assign z0_nxt = neg_r ? -signed'({1'b0, zmag_w}) : signed'({1'b0, zmag_w});

  // CORDIC stages, one micro-rotation per register stage.
  logic signed [CW-1:0] x_in  [CS];
  logic signed [CW-1:0] y_in  [CS];
  logic signed [63:0]   z_in  [CS];
  logic signed [CW-1:0] x_nxt [CS];
  logic signed [CW-1:0] y_nxt [CS];
  logic signed [63:0]   z_nxt [CS];
  logic signed [CW-1:0] x_r   [CS];
  logic signed [CW-1:0] y_r   [CS];
  logic signed [63:0]   z_r   [CS];

  assign x_in[0] = ONE_C;
  assign y_in[0] = '0;
  assign z_in[0] = z0_r;

  for (genvar g = 0; g < CS; g++) begin : g_step
    localparam logic signed [63:0] ATAN = e313q_pkg::atan_entry(g);
    if (g > 0) begin : g_link
      assign x_in[g] = x_r[g-1];
      assign y_in[g] = y_r[g-1];
      assign z_in[g] = z_r[g-1];
    end
    assign x_nxt[g] = z_in[g][63] ? x_in[g] + (y_in[g] >>> g) : x_in[g] - (y_in[g] >>> g);
    assign y_nxt[g] = z_in[g][63] ? y_in[g] - (x_in[g] >>> g) : y_in[g] + (x_in[g] >>> g);
    assign z_nxt[g] = z_in[g][63] ? z_in[g] + ATAN : z_in[g] - ATAN;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_ll_r <= p_ll_nxt;
      p_lh_r <= p_lh_nxt;
      p_hl_r <= p_hl_nxt;
      p_hh_r <= p_hh_nxt;
      neg_r  <= neg_nxt;
      z0_r   <= z0_nxt;
      for (int g = 0; g < CS; g++) begin
        x_r[g] <= x_nxt[g];
        y_r[g] <= y_nxt[g];
        z_r[g] <= z_nxt[g];
      end
    end
  end

  assign cos_o = x_r[CS-1];
  assign sin_o = y_r[CS-1];

endmodule

// File: design/e313q_combine.sv
// Merging stage: forms the four unnormalized quaternion components from the lane results.
module e313q_combine #(
  parameter int FB = 30
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [FB+1:0] cp,
  input  logic signed [FB+1:0] sp,
  input  logic signed [FB+1:0] ct,
  input  logic signed [FB+1:0] st,
  input  logic signed [FB+1:0] cv,
  input  logic signed [FB+1:0] sv,
  output logic signed [FB+4:0] q_o [4]
);

  localparam int CW = FB + 2;
  localparam int PW = 2 * CW;
  localparam int TW = FB + 3;
  localparam int QW = FB + 5;
  localparam logic [PW-1:0] HALF = PW'(1) << (FB - 1);
  localparam int A_SEL [8] = '{0, 1, 2, 3, 3, 2, 1, 0};

  function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
    return v[CW-1] ? CW'(-v) : CW'(v);
  endfunction

  // First products: cp*ct, sp*ct, cp*st, sp*st.
  logic signed [CW-1:0] fa [4];
  logic signed [CW-1:0] fb [4];
  logic [PW-1:0] p1_nxt [4];
  logic [PW-1:0] p1_r   [4];
  logic [3:0]    s1_nxt, s1_r, s1d_r;
  logic signed [CW-1:0] cv1_r, sv1_r, cv2_r, sv2_r;

  assign fa = '{cp, sp, cp, sp};
  assign fb = '{ct, ct, st, st};

  for (genvar k = 0; k < 4; k++) begin : g_p1
    assign p1_nxt[k] = PW'(mag(fa[k])) * PW'(mag(fb[k]));
    assign s1_nxt[k] = fa[k][CW-1] ^ fb[k][CW-1];
  end

  // Round the first products.
  logic [CW-1:0] m1_nxt [4];
  logic [CW-1:0] m1_r   [4];

  for (genvar k = 0; k < 4; k++) begin : g_m1
    assign m1_nxt[k] = CW'((p1_r[k] + HALF) >> FB);
  end

  // Second products; even terms take the spin cosine, odd terms the spin sine.
  logic [PW-1:0] p2_nxt [8];
  logic [PW-1:0] p2_r   [8];
  logic [7:0]    s2_nxt, s2_r;

  for (genvar j = 0; j < 8; j++) begin : g_p2
    if ((j & 1) == 0) begin : g_c
      assign p2_nxt[j] = PW'(m1_r[A_SEL[j]]) * PW'(mag(cv2_r));
      assign s2_nxt[j] = s1d_r[A_SEL[j]] ^ cv2_r[CW-1];
    end else begin : g_s
      assign p2_nxt[j] = PW'(m1_r[A_SEL[j]]) * PW'(mag(sv2_r));
      assign s2_nxt[j] = s1d_r[A_SEL[j]] ^ sv2_r[CW-1];
    end
  end

  // Round the terms and add them in pairs.
  logic [TW-1:0]        m2_w [8];
  logic signed [QW-1:0] t_w  [8];
  logic signed [QW-1:0] q_nxt [4];
  logic signed [QW-1:0] q_r   [4];

  for (genvar j = 0; j < 8; j++) begin : g_t
    assign m2_w[j] = TW'((p2_r[j] + HALF) >> FB);
    assign t_w[j]  = s2_r[j] ? -signed'(QW'(m2_w[j])) : signed'(QW'(m2_w[j]));
  end

  assign q_nxt[0] = t_w[0] - t_w[1];
  assign q_nxt[1] = t_w[2] + t_w[3];
  assign q_nxt[2] = t_w[4] - t_w[5];
  assign q_nxt[3] = t_w[6] + t_w[7];

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r  <= p1_nxt;
      s1_r  <= s1_nxt;
      cv1_r <= cv;
      sv1_r <= sv;
      m1_r  <= m1_nxt;
      s1d_r <= s1_r;
      cv2_r <= cv1_r;
      sv2_r <= sv1_r;
      p2_r  <= p2_nxt;
      s2_r  <= s2_nxt;
      q_r   <= q_nxt;
    end
  end

  assign q_o = q_r;

endmodule

// File: design/e313q_sqrt.sv
// Sum of squares and a pipelined digit-by-digit integer square root, one root bit per stage.
module e313q_sqrt #(
  parameter int FB = 30
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [FB+4:0] q_i    [4],
  output logic [FB+5:0]        root_o,
  output logic signed [FB+4:0] q_o    [4]
);

  localparam int QW  = FB + 5;
  localparam int SQW = 2 * QW;
  localparam int SW  = SQW + 2;
  localparam int RW  = QW + 1;
  localparam int TW  = SW + 1;

  function automatic logic [QW-1:0] mag(input logic signed [QW-1:0] v);
    return v[QW-1] ? QW'(-v) : QW'(v);
  endfunction

  logic [SQW-1:0]       sq_nxt [4];
  logic [SQW-1:0]       sq_r   [4];
  logic signed [QW-1:0] q1_r   [4];
  logic signed [QW-1:0] q2_r   [4];
  logic [SW-1:0]        sum_nxt, sum_r;

  for (genvar k = 0; k < 4; k++) begin : g_sq
    assign sq_nxt[k] = SQW'(mag(q_i[k])) * SQW'(mag(q_i[k]));
  end

  assign sum_nxt = SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]) + SW'(sq_r[3]);

  // Each stage keeps the remainder sum - root^2 and settles one root bit.
  logic [SW-1:0]        rem_in   [RW];
  logic [RW-1:0]        root_in  [RW];
  logic [SW-1:0]        rem_nxt  [RW];
  logic [RW-1:0]        root_nxt [RW];
  logic [SW-1:0]        rem_r    [RW];
  logic [RW-1:0]        root_r   [RW];
  logic signed [QW-1:0] qp_r     [RW][4];

  assign rem_in[0]  = sum_r;
  assign root_in[0] = '0;

  for (genvar j = 0; j < RW; j++) begin : g_bit
    localparam int B = RW - 1 - j;
    logic [TW-1:0] trial;
    logic          take;
    if (j > 0) begin : g_link
      assign rem_in[j]  = rem_r[j-1];
      assign root_in[j] = root_r[j-1];
    end
    assign trial       = (TW'(root_in[j]) << (B + 1)) | (TW'(1) << (2 * B));
    assign take        = TW'(rem_in[j]) >= trial;
    assign rem_nxt[j]  = take ? SW'(TW'(rem_in[j]) - trial) : rem_in[j];
    assign root_nxt[j] = take ? (root_in[j] | (RW'(1) << B)) : root_in[j];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r  <= sq_nxt;
      q1_r  <= q_i;
      sum_r <= sum_nxt;
      q2_r  <= q1_r;
      for (int j = 0; j < RW; j++) begin
        rem_r[j]  <= rem_nxt[j];
        root_r[j] <= root_nxt[j];
      end
      qp_r[0] <= q2_r;
      for (int j = 1; j < RW; j++) begin
        qp_r[j] <= qp_r[j-1];
      end
    end
  end

  assign root_o = root_r[RW-1];
  assign q_o    = qp_r[RW-1];

endmodule

// File: design/e313q_div.sv
// One normalization lane: rounded quotient of a component by the root, one quotient bit per stage.
module e313q_div #(
  parameter int FB = 30
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [FB+4:0] q_i,
  input  logic [FB+5:0]        root_i,
  output logic [FB:0]          quo_o,
  output logic                 neg_o,
  output logic                 zero_o
);

  localparam int QW  = FB + 5;
  localparam int RW  = QW + 1;
  localparam int NW  = QW + FB + 2;
  localparam int DW  = RW + 1;
  localparam int CTW = NW + 1;
  localparam int QTW = FB + 1;

  logic [QW-1:0] mag_w;
  logic [NW-1:0] num_nxt, num_r;
  logic [DW-1:0] den0_r;
  logic          neg0_r, zero0_r;

  assign mag_w   = q_i[QW-1] ? QW'(-q_i) : QW'(q_i);
  assign num_nxt = (NW'(mag_w) << (FB + 1)) + NW'(root_i);

  logic [NW-1:0]  rem_in  [QTW];
  logic [QTW-1:0] quo_in  [QTW];
  logic [DW-1:0]  den_in  [QTW];
  logic           neg_in  [QTW];
  logic           zero_in [QTW];
  logic [NW-1:0]  rem_nxt [QTW];
  logic [QTW-1:0] quo_nxt [QTW];
  logic [NW-1:0]  rem_r   [QTW];
  logic [QTW-1:0] quo_r   [QTW];
  logic [DW-1:0]  den_r   [QTW];
  logic           neg_r   [QTW];
  logic           zero_r  [QTW];

  assign rem_in[0]  = num_r;
  assign quo_in[0]  = '0;
  assign den_in[0]  = den0_r;
  assign neg_in[0]  = neg0_r;
  assign zero_in[0] = zero0_r;

  for (genvar j = 0; j < QTW; j++) begin : g_bit
    localparam int B = QTW - 1 - j;
    logic [CTW-1:0] trial;
    logic           take;
    if (j > 0) begin : g_link
      assign rem_in[j]  = rem_r[j-1];
      assign quo_in[j]  = quo_r[j-1];
      assign den_in[j]  = den_r[j-1];
      assign neg_in[j]  = neg_r[j-1];
      assign zero_in[j] = zero_r[j-1];
    end
    assign trial      = CTW'(den_in[j]) << B;
    assign take       = CTW'(rem_in[j]) >= trial;
    assign rem_nxt[j] = take ? NW'(CTW'(rem_in[j]) - trial) : rem_in[j];
    assign quo_nxt[j] = take ? (quo_in[j] | (QTW'(1) << B)) : quo_in[j];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r   <= num_nxt;
      den0_r  <= {root_i, 1'b0};
      neg0_r  <= q_i[QW-1];
      zero0_r <= (root_i == '0);
      for (int j = 0; j < QTW; j++) begin
        rem_r[j]  <= rem_nxt[j];
        quo_r[j]  <= quo_nxt[j];
        den_r[j]  <= den_in[j];
        neg_r[j]  <= neg_in[j];
        zero_r[j] <= zero_in[j];
      end
    end
  end

  assign quo_o  = quo_r[QTW-1];
  assign neg_o  = neg_r[QTW-1];
  assign zero_o = zero_r[QTW-1];

endmodule

// File: design/euler_313_to_quaternion.sv
// Throughput: one transaction per cycle; every CORDIC rotation, root bit and quotient bit has its own stage.
// A stalled result holds the whole pipeline, and the input is stalled in the same cycle.
// Reset (rst_n low at a clock edge) clears only the valid bits; data registers carry no reset.
// The output register is the last pipeline stage and holds while a finished result waits under out_stall.
module euler_313_to_quaternion #(
  parameter int ANGLE_WIDTH   = 32,
  parameter int FRACTION_BITS = 30,
  parameter int CORDIC_STEPS  = 30
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [ANGLE_WIDTH-1:0]   in_precession_angle,
  input  logic signed [ANGLE_WIDTH-1:0]   in_nutation_angle,
  input  logic signed [ANGLE_WIDTH-1:0]   in_spin_angle,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [FRACTION_BITS+1:0] out_q_scalar,
  output logic signed [FRACTION_BITS+1:0] out_q_x,
  output logic signed [FRACTION_BITS+1:0] out_q_y,
  output logic signed [FRACTION_BITS+1:0] out_q_z
);

  localparam int FB  = FRACTION_BITS;
  localparam int CW  = FB + 2;
  localparam int QW  = FB + 5;
  localparam int RW  = QW + 1;
  localparam int OW  = FB + 2;
  // Stage counts: angle lanes, merging stage, root, divider lanes, output register.
  localparam int LAT = (2 + CORDIC_STEPS) + 4 + (2 + RW) + (FB + 2) + 1;
  localparam logic [FB:0] ONE_Q = (FB + 1)'(1) << FB;

  // The pipeline advances unless a finished result is waiting to be taken.
  logic en;
  logic [LAT-1:0] vld_r, vld_nxt;

  assign en       = ~(vld_r[LAT-1] & out_stall);
  assign in_stall = ~en;
  assign vld_nxt  = {vld_r[LAT-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // Three CORDIC lanes work side by side on the precession, nutation and spin angles.
  logic signed [CW-1:0] cp, sp, ct, st, cv, sv;

  e313q_cordic #(.AW(ANGLE_WIDTH), .FB(FB), .CS(CORDIC_STEPS)) u_lane_prec (
    .clk(clk), .en(en), .angle(in_precession_angle), .unused_tie(1'b0),
    .cos_o(cp), .sin_o(sp)
  );

  e313q_cordic #(.AW(ANGLE_WIDTH), .FB(FB), .CS(CORDIC_STEPS)) u_lane_nut (
    .clk(clk), .en(en), .angle(in_nutation_angle), .unused_tie(1'b0),
    .cos_o(ct), .sin_o(st)
  );

  e313q_cordic #(.AW(ANGLE_WIDTH), .FB(FB), .CS(CORDIC_STEPS)) u_lane_spin (
    .clk(clk), .en(en), .angle(in_spin_angle), .unused_tie(1'b0),
    .cos_o(cv), .sin_o(sv)
  );

  // The merging stage forms the components; the CORDIC gain stays in and is
  // cancelled by the normalization below.
  logic signed [QW-1:0] q_raw [4];

  e313q_combine #(.FB(FB)) u_combine (
    .clk(clk), .en(en),
    .cp(cp), .sp(sp), .ct(ct), .st(st), .cv(cv), .sv(sv),
    .q_o(q_raw)
  );

  // Root of the exact sum of squares, with the components carried alongside.
  logic [RW-1:0]        root;
  logic signed [QW-1:0] q_dly [4];

  e313q_sqrt #(.FB(FB)) u_sqrt (
    .clk(clk), .en(en), .q_i(q_raw), .root_o(root), .q_o(q_dly)
  );

  // Four divider lanes, one per component, followed by the output register.
  logic [FB:0]          quo  [4];
  logic [3:0]           neg, zero;
  logic [FB:0]          val_w   [4];
  logic signed [OW-1:0] out_nxt [4];
  logic signed [OW-1:0] out_r   [4];

  for (genvar k = 0; k < 4; k++) begin : g_norm
    e313q_div #(.FB(FB)) u_div (
      .clk(clk), .en(en), .q_i(q_dly[k]), .root_i(root),
      .quo_o(quo[k]), .neg_o(neg[k]), .zero_o(zero[k])
    );

    // A zero root would give the identity rotation; a quotient above one saturates.
    if (k == 0) begin : g_scalar
      assign val_w[k] = zero[k] ? ONE_Q : ((quo[k] > ONE_Q) ? ONE_Q : quo[k]);
    end else begin : g_vector
      assign val_w[k] = zero[k] ? '0 : ((quo[k] > ONE_Q) ? ONE_Q : quo[k]);
    end
    assign out_nxt[k] = (neg[k] & ~zero[k]) ? -signed'(OW'(val_w[k])) : signed'(OW'(val_w[k]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid    = vld_r[LAT-1];
  assign out_q_scalar = out_r[0];
  assign out_q_x      = out_r[1];
  assign out_q_y      = out_r[2];
  assign out_q_z      = out_r[3];

endmodule
